>>> rtl/core/comment_stripper_macros.svh
`ifndef COMMENT_STRIPPER_MACROS_SVH
`define COMMENT_STRIPPER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("comment_stripper check failed");

// next-cycle implication, checked while out of reset
`define CS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("comment_stripper check failed");

`endif

>>> rtl/core/cs_pkg.sv
package cs_pkg;

    localparam int CS_Q_DEPTH = 4;
    localparam int CS_PTR_W   = 2;
    localparam int CS_CNT_W   = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [4:0] {
        MODE_CODE  = 5'b00001,
        MODE_STR   = 5'b00010,
        MODE_CHR   = 5'b00100,
        MODE_LINE  = 5'b01000,
        MODE_BLOCK = 5'b10000
    } t_lex_mode;

    typedef struct packed {
        t_lex_mode  mode;
        logic       esc;
        logic       consumed;
        logic [7:0] ch;
    } t_lex_res;

    typedef struct packed {
        logic [7:0] clean_byte;
        logic       run_last;
        logic       final_char;
    } t_q_entry;

    // one lexer step on byte cur with lookahead nxt
    function automatic t_lex_res cs_lex(t_lex_mode mode, logic esc,
                                        logic [7:0] cur, logic [7:0] nxt);
        t_lex_res r;
        logic     is_lit;
        r.mode     = mode;
        r.esc      = esc;
        r.consumed = 1'b0;
        r.ch       = cur;
        is_lit     = (mode == MODE_STR) || (mode == MODE_CHR);
        case (mode)
            MODE_LINE: begin
                if (cur == CH_NL) begin
                    r.mode = MODE_CODE;
                    r.ch   = CH_NL;
                end else begin
                    r.ch = CH_SPACE;
                end
            end
            MODE_BLOCK: begin
                if (cur == CH_STAR && nxt == CH_SLASH) begin
                    r.mode     = MODE_CODE;
                    r.ch       = CH_SPACE;
                    r.consumed = 1'b1;
                end else begin
                    r.ch = (cur == CH_NL) ? CH_NL : CH_SPACE;
                end
            end
            default: begin
                if (!is_lit && cur == CH_SLASH && (nxt == CH_SLASH || nxt == CH_STAR)) begin
                    r.mode     = (nxt == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    r.ch       = CH_SPACE;
                    r.consumed = 1'b1;
                end else if (esc) begin
                    r.esc = 1'b0;
                end else if (is_lit && cur == CH_BSLASH) begin
                    r.esc = 1'b1;
                end else if (mode != MODE_CHR && cur == CH_DQUOTE) begin
                    r.mode = (mode == MODE_STR) ? MODE_CODE : MODE_STR;
                end else if (mode != MODE_STR && cur == CH_SQUOTE) begin
                    r.mode = (mode == MODE_CHR) ? MODE_CODE : MODE_CHR;
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/cs_in_if.sv
interface cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> rtl/core/cs_out_if.sv
interface cs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] clean_byte;
    logic       run_last;
    logic       final_char;

    modport source (output valid, output clean_byte, output run_last, output final_char,
                    input ready);
    modport sink   (input valid, input clean_byte, input run_last, input final_char,
                    output ready);
endinterface

>>> rtl/core/comment_stripper.sv
// Streaming C-style comment stripper. Every input byte gives one output byte: line and
// block comments come out as spaces, newlines inside comments are kept, and comment
// openers inside string or character literals are ignored (backslash escapes the next
// literal byte). One byte is held for lookahead, so an item gives zero, one or two
// results; the first byte of a text gives none until the next byte arrives, and an item
// with end_of_text flushes the held byte and returns the lexer to its reset state.
// The lexer step is combinational logic on accept; results go into a 4-entry queue and
// leave one per cycle while o_out.ready is high. An item is taken every cycle while the
// queue has two free entries, which sustains one byte per cycle as the lengths match.
`include "comment_stripper_macros.svh"

module comment_stripper
    import cs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cs_in_if.sink    i_in,
    cs_out_if.source o_out
);

    t_lex_mode            r_mode;
    logic                 r_esc;
    logic [7:0]           r_held;
    logic                 r_held_valid;

    t_q_entry             r_q [CS_Q_DEPTH];
    logic [CS_PTR_W-1:0]  r_wr_ptr;
    logic [CS_PTR_W-1:0]  r_rd_ptr;
    logic [CS_CNT_W-1:0]  r_count;

    logic                 acc;
    logic                 pop;
    t_lex_res             lx_a;
    t_lex_res             lx_b;
    t_lex_mode            mode_a;
    logic                 esc_a;
    logic                 hv_a;
    logic [1:0]           push_n;
    logic [7:0]           byte0;
    logic [7:0]           byte1;
    t_q_entry             e0;
    t_q_entry             e1;

    assign acc = i_in.valid & i_in.ready;
    assign pop = o_out.valid & o_out.ready;

    // no item is taken while reset is held
    assign i_in.ready = i_rst_n && (r_count <= CS_CNT_W'(CS_Q_DEPTH - 2));

    always_comb begin
        lx_a   = cs_lex(r_mode, r_esc, r_held, i_in.text_byte);
        mode_a = r_mode;
        esc_a  = r_esc;
        hv_a   = 1'b1;
        push_n = 2'd0;
        byte0  = CH_SPACE;
        byte1  = CH_SPACE;
        if (r_held_valid) begin
            mode_a = lx_a.mode;
            esc_a  = lx_a.esc;
            if (lx_a.consumed) begin
                // two-byte mark: both bytes become spaces
                push_n = 2'd2;
                hv_a   = 1'b0;
            end else begin
                push_n = 2'd1;
                byte0  = lx_a.ch;
            end
        end
        // flush of the new byte with a nul lookahead
        lx_b = cs_lex(mode_a, esc_a, i_in.text_byte, CH_NUL);
        if (i_in.end_of_text && hv_a) begin
            if (push_n == 2'd0) begin
                byte0 = lx_b.ch;
            end else begin
                byte1 = lx_b.ch;
            end
            push_n = push_n + 2'd1;
        end
        if (!acc) begin
            push_n = 2'd0;
        end
        e0.clean_byte = byte0;
        e0.run_last   = (push_n == 2'd1);
        e0.final_char = (push_n == 2'd1) && i_in.end_of_text;
        e1.clean_byte = byte1;
        e1.run_last   = 1'b1;
        e1.final_char = i_in.end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CODE;
            r_esc        <= 1'b0;
            r_held       <= CH_NUL;
            r_held_valid <= 1'b0;
        end else if (acc) begin
            if (i_in.end_of_text) begin
                r_mode       <= MODE_CODE;
                r_esc        <= 1'b0;
                r_held       <= CH_NUL;
                r_held_valid <= 1'b0;
            end else begin
                r_mode       <= mode_a;
                r_esc        <= esc_a;
                r_held       <= hv_a ? i_in.text_byte : CH_NUL;
                r_held_valid <= hv_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= e0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + CS_PTR_W'(1)] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + CS_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + CS_PTR_W'(pop);
            r_count  <= r_count + CS_CNT_W'(push_n) - CS_CNT_W'(pop);
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.clean_byte = r_q[r_rd_ptr].clean_byte;
    assign o_out.run_last   = r_q[r_rd_ptr].run_last;
    assign o_out.final_char = r_q[r_rd_ptr].final_char;

    `CS_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= CS_CNT_W'(CS_Q_DEPTH))
    `CS_ASSERT_NEXT(a_eot_resets, acc && i_in.end_of_text, !r_held_valid && r_mode == MODE_CODE)
    `CS_ASSERT_NEXT(a_held_gives_result, acc && r_held_valid, r_count != '0)
    `CS_ASSERT_NOW(a_final_is_last, o_out.valid && o_out.final_char, o_out.run_last)

endmodule

>>> test/tb_comment_stripper.sv
module tb_comment_stripper;
    import cs_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 320;

    typedef enum int {
        TOK_CODE,
        TOK_LINE,
        TOK_BLOCK,
        TOK_STR,
        TOK_CHR,
        TOK_NOISE
    } t_tok_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cs_in_if  in_if ();
    cs_out_if out_if ();

    comment_stripper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // lexer state of the predictor
    t_lex_mode  lex_mode;
    logic       esc_pend;
    logic [7:0] held_ch;
    logic       held_ok;

    logic [7:0] step_bytes[$];
    t_q_entry   clean_q[$];
    logic [7:0] text_buf[$];

    int gap_max;
    int stall_max;
    int stall_cnt;
    int n_sent;
    int errors;
    int idle_cycles;
    t_q_entry exp_e;

    function automatic void reset_lexer();
        lex_mode = MODE_CODE;
        esc_pend = 1'b0;
        held_ch  = CH_NUL;
        held_ok  = 1'b0;
    endfunction

    // append one predicted output byte of the current step
    function automatic void put_step(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    // append one byte to the text being built
    function automatic void put_text(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    // one lexer step on cur with lookahead nxt; returns 1 when nxt is eaten too
    function automatic logic lex_one(input logic [7:0] cur, input logic [7:0] nxt);
        logic in_lit;
        in_lit = (lex_mode == MODE_STR) || (lex_mode == MODE_CHR);
        if (lex_mode == MODE_LINE) begin
            put_step((cur == CH_NL) ? CH_NL : CH_SPACE);
            if (cur == CH_NL)
                lex_mode = MODE_CODE;
            return 1'b0;
        end
        if (lex_mode == MODE_BLOCK) begin
            if (cur == CH_STAR && nxt == CH_SLASH) begin
                lex_mode = MODE_CODE;
                put_step(CH_SPACE);
                put_step(CH_SPACE);
                return 1'b1;
            end
            put_step((cur == CH_NL) ? CH_NL : CH_SPACE);
            return 1'b0;
        end
        if (!in_lit && cur == CH_SLASH && (nxt == CH_SLASH || nxt == CH_STAR)) begin
            lex_mode = (nxt == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            put_step(CH_SPACE);
            put_step(CH_SPACE);
            return 1'b1;
        end
        put_step(cur);
        if (esc_pend)
            esc_pend = 1'b0;
        else if (in_lit && cur == CH_BSLASH)
            esc_pend = 1'b1;
        else if (lex_mode != MODE_CHR && cur == CH_DQUOTE)
            lex_mode = (lex_mode == MODE_STR) ? MODE_CODE : MODE_STR;
        else if (lex_mode != MODE_STR && cur == CH_SQUOTE)
            lex_mode = (lex_mode == MODE_CHR) ? MODE_CODE : MODE_CHR;
        return 1'b0;
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic eot);
        t_q_entry e;
        step_bytes = {};
        if (held_ok && lex_one(held_ch, b)) begin
            held_ok = 1'b0;
            held_ch = CH_NUL;
        end else begin
            held_ch = b;
            held_ok = 1'b1;
        end
        if (eot) begin
            // flush with a nul lookahead, then start a fresh text
            if (held_ok)
                void'(lex_one(held_ch, CH_NUL));
            reset_lexer();
        end
        foreach (step_bytes[i]) begin
            e.clean_byte = step_bytes[i];
            e.run_last   = (i == step_bytes.size() - 1);
            e.final_char = eot && (i == step_bytes.size() - 1);
            clean_q.insert(clean_q.size(), e);
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.text_byte   <= b;
        in_if.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predict_item(b, eot);
        n_sent++;
    endtask

    // sends text_buf as one text, end_of_text on its last byte
    task automatic send_text();
        foreach (text_buf[i])
            send_item(text_buf[i], i == text_buf.size() - 1);
    endtask

    function automatic logic [7:0] body_char();
        case ($urandom_range(0, 11))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_NL;
            3: return CH_BSLASH;
            4: return CH_DQUOTE;
            5: return CH_SQUOTE;
            6: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void add_token(input t_tok_kind k);
        int n;
        n = $urandom_range(0, 4);
        case (k)
            TOK_LINE: begin
                put_text(CH_SLASH);
                put_text(CH_SLASH);
                repeat (n) put_text(body_char());
                put_text(CH_NL);
            end
            TOK_BLOCK: begin
                put_text(CH_SLASH);
                put_text(CH_STAR);
                repeat (n) put_text(body_char());
                put_text(CH_STAR);
                put_text(CH_SLASH);
            end
            TOK_STR: begin
                put_text(CH_DQUOTE);
                repeat (n) put_text(body_char());
                put_text(CH_DQUOTE);
            end
            TOK_CHR: begin
                put_text(CH_SQUOTE);
                repeat (n % 3) put_text(body_char());
                put_text(CH_SQUOTE);
            end
            TOK_NOISE: begin
                repeat (n + 1) put_text(8'($urandom_range(0, 255)));
            end
            default: begin
                repeat (n + 1) put_text(body_char());
            end
        endcase
    endfunction

    task automatic test_flush_cases();
        text_buf = {8'hFF};
        send_text();
        text_buf = {CH_SLASH};
        send_text();
        // block comment left open at end of text
        text_buf = {CH_SLASH, CH_STAR};
        send_text();
    endtask

    task automatic test_line_comment();
        text_buf = {CH_SLASH, CH_SLASH, 8'h78, CH_NL, CH_NUL};
        send_text();
    endtask

    task automatic test_block_comment();
        text_buf = {CH_SLASH, CH_STAR, CH_NL, CH_STAR, CH_SLASH};
        send_text();
    endtask

    task automatic test_literals();
        // escaped quote, then a comment opener inside the string
        text_buf = {CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_SLASH, CH_SLASH, CH_SQUOTE};
        send_text();
        text_buf = {CH_SQUOTE, CH_SLASH, CH_STAR, CH_SQUOTE};
        send_text();
    endtask

    task automatic test_random_texts();
        int start;
        int phase;
        start = n_sent;
        phase = 0;
        while (n_sent - start < RANDOM_ITEMS) begin
            // phases with and without idling on either side
            gap_max   = (phase % 4 < 2) ? 10 : 0;
            stall_max = (phase % 2 == 0) ? 10 : 0;
            repeat (8) begin
                if (n_sent - start < RANDOM_ITEMS) begin
                    text_buf = {};
                    repeat ($urandom_range(1, 5))
                        add_token(t_tok_kind'($urandom_range(0, 5)));
                    send_text();
                end
            end
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (clean_q.size() == 0) begin
                    $error("unexpected item: clean_byte %h", out_if.clean_byte);
                    errors++;
                end else begin
                    exp_e = clean_q.pop_front();
                    if (out_if.clean_byte !== exp_e.clean_byte) begin
                        $error("clean_byte: expected %h, actual %h",
                               exp_e.clean_byte, out_if.clean_byte);
                        errors++;
                    end
                    if (out_if.run_last !== exp_e.run_last) begin
                        $error("run_last: expected %b, actual %b",
                               exp_e.run_last, out_if.run_last);
                        errors++;
                    end
                    if (out_if.final_char !== exp_e.final_char) begin
                        $error("final_char: expected %b, actual %b",
                               exp_e.final_char, out_if.final_char);
                        errors++;
                    end
                end
                stall_cnt = $urandom_range(0, stall_max);
            end else if (stall_cnt > 0) begin
                stall_cnt--;
            end
            out_if.ready <= (stall_cnt == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** comment_stripper: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid       <= 1'b0;
        in_if.text_byte   <= 8'h00;
        in_if.end_of_text <= 1'b0;
        errors      = 0;
        n_sent      = 0;
        idle_cycles = 0;
        gap_max     = 10;
        stall_max   = 10;
        reset_lexer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_flush_cases();
        test_line_comment();
        test_block_comment();
        test_literals();
        test_random_texts();

        in_if.valid <= 1'b0;
        while (clean_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (clean_q.size() != 0) begin
            $error("%0d expected items never arrived", clean_q.size());
            errors++;
        end
        if (errors == 0)
            $display("** comment_stripper: PASSED **");
        else
            $display("** comment_stripper: FAILED **");
        $finish;
    end

endmodule
